>>> rtl/rbdw_pkg.sv
// shared types and constants for the byte ring buffer
`timescale 1ns / 1ps
package rbdw_pkg;

  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_CAPACITY = 3'd0;

  typedef enum logic [2:0] {
    OP_CLEAR       = 3'd0,
    OP_WRITE       = 3'd1,
    OP_READ        = 3'd2,
    OP_PEEK        = 3'd3,
    OP_COMMIT_IN   = 3'd4,
    OP_COMMIT_OUT  = 3'd5,
    OP_PREPARE_IN  = 3'd6,
    OP_PREPARE_OUT = 3'd7
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [12:0] length;
    logic        first;
    logic [7:0]  data_byte;
    logic [11:0] index;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  byte_out;
    logic [12:0] amount;
    logic [1:0]  seg_count;
    logic [11:0] seg0_offset;
    logic [12:0] seg0_len;
    logic [12:0] seg1_len;
  } out_t;

  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/rbdw_regs.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps
module rbdw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbdw_pkg::APB_AW-1:0]   paddr,
  input  logic [rbdw_pkg::APB_DW-1:0]   pwdata,
  output logic [rbdw_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output rbdw_pkg::cfg_t                cfg_o
);

  logic [rbdw_pkg::CNT_W-1:0] cap_raw_q, cap_raw_d;
  logic [rbdw_pkg::CNT_W-1:0] cap_eff_q, cap_eff_d;
  logic                       wr_en;
  logic                       sel_cap;
  logic [rbdw_pkg::CNT_W-1:0] wval;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[rbdw_pkg::APB_AW-1:2] == rbdw_pkg::REG_CAPACITY[rbdw_pkg::APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready && sel_cap;
  assign wval    = pwdata[rbdw_pkg::CNT_W-1:0];

  always_comb begin
    cap_raw_d = cap_raw_q;
    cap_eff_d = cap_eff_q;
    if (wr_en) begin
      cap_raw_d = wval;
      if (wval == '0 || wval > rbdw_pkg::CNT_W'(rbdw_pkg::DEPTH)) begin
        cap_eff_d = rbdw_pkg::CNT_W'(rbdw_pkg::DEPTH);
      end else begin
        cap_eff_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q <= rbdw_pkg::CNT_W'(rbdw_pkg::DEPTH);
      cap_eff_q <= rbdw_pkg::CNT_W'(rbdw_pkg::DEPTH);
    end else begin
      cap_raw_q <= cap_raw_d;
      cap_eff_q <= cap_eff_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = rbdw_pkg::APB_DW'(cap_raw_q);
    end
  end

  // buffer empties at the same edge that takes the new capacity
  assign cfg_o.clear = wr_en;
  assign cfg_o.cap   = cap_eff_q;

endmodule

>>> rtl/rbdw_store.sv
// byte store with one write port and one registered read port
`timescale 1ns / 1ps
module rbdw_store (
  input  logic               clk_i,
  input  rbdw_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [rbdw_pkg::DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rbdw_ctrl.sv
// pointer and fill bookkeeping, handshake and result register
`timescale 1ns / 1ps
module rbdw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbdw_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbdw_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbdw_pkg::out_t     out_data_o,
  output rbdw_pkg::mem_req_t mem_req_o,
  input  logic [7:0]         mem_rdata_i
);

  localparam int unsigned AW = rbdw_pkg::ADDR_W;
  localparam int unsigned CW = rbdw_pkg::CNT_W;

  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          bok_q, bok_d;
  logic          vld_q, vld_d;
  logic          rsel_q, rsel_d;
  rbdw_pkg::out_t res_q, res_d;

  logic          accept;
  logic [CW-1:0] cap;
  logic [CW-1:0] free_sp;
  logic [CW-1:0] clip_len;
  logic [CW-1:0] room;
  logic [CW-1:0] total;
  logic [AW-1:0] seg_ptr;
  logic          bok_next;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [CW-1:0] n,
                                             input logic [CW-1:0] c);
    logic [CW:0] s;
    logic [CW:0] r;
    s = {2'b00, p} + {1'b0, n};
    r = (s >= {1'b0, c}) ? (s - {1'b0, c}) : s;
    return r[AW-1:0];
  endfunction

  assign cap        = cfg_i.cap;
  assign in_stall_o = vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign free_sp    = cap - fill_q;
  assign clip_len   = (in_data_i.length > fill_q) ? fill_q : in_data_i.length;
  assign bok_next   = in_data_i.first ? ((in_data_i.length != '0) &&
                                         (in_data_i.length <= free_sp)) : bok_q;
  assign total      = (in_data_i.op == rbdw_pkg::OP_PREPARE_IN) ? free_sp : fill_q;
  assign seg_ptr    = (in_data_i.op == rbdw_pkg::OP_PREPARE_IN) ? wp_q : rp_q;
  assign room       = cap - {1'b0, seg_ptr};

  always_comb begin
    fill_d    = fill_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    bok_d     = bok_q;
    rsel_d    = rsel_q;
    res_d     = res_q;
    mem_req_o = '0;
    mem_req_o.waddr = wp_q;
    mem_req_o.wdata = in_data_i.data_byte;
    mem_req_o.raddr = rp_q;
    if (accept) begin
      res_d          = '0;
      rsel_d         = 1'b0;
      mem_req_o.re   = 1'b1;
      case (in_data_i.op)
        rbdw_pkg::OP_CLEAR: begin
          fill_d   = '0;
          rp_d     = '0;
          wp_d     = '0;
          bok_d    = 1'b0;
          res_d.ok = 1'b1;
        end
        rbdw_pkg::OP_WRITE: begin
          bok_d = bok_next;
          if (bok_next && fill_q < cap) begin
            mem_req_o.we = 1'b1;
            wp_d         = wrap_add(wp_q, CW'(1), cap);
            fill_d       = fill_q + CW'(1);
            res_d.ok     = 1'b1;
          end
        end
        rbdw_pkg::OP_READ: begin
          if (fill_q != '0) begin
            res_d.ok = 1'b1;
            rsel_d   = 1'b1;
            rp_d     = wrap_add(rp_q, CW'(1), cap);
            fill_d   = fill_q - CW'(1);
          end
        end
        rbdw_pkg::OP_PEEK: begin
          mem_req_o.raddr = wrap_add(rp_q, {1'b0, in_data_i.index}, cap);
          if ({1'b0, in_data_i.index} < fill_q) begin
            res_d.ok = 1'b1;
            rsel_d   = 1'b1;
          end
        end
        rbdw_pkg::OP_COMMIT_IN: begin
          if (in_data_i.length <= free_sp) begin
            fill_d       = fill_q + in_data_i.length;
            wp_d         = wrap_add(wp_q, in_data_i.length, cap);
            res_d.ok     = 1'b1;
            res_d.amount = free_sp - in_data_i.length;
          end
        end
        rbdw_pkg::OP_COMMIT_OUT: begin
          fill_d       = fill_q - clip_len;
          rp_d         = wrap_add(rp_q, clip_len, cap);
          res_d.ok     = 1'b1;
          res_d.amount = fill_q - clip_len;
        end
        default: begin
          if (total != '0) begin
            res_d.ok          = 1'b1;
            res_d.seg0_offset = seg_ptr;
            if (total > room) begin
              res_d.seg_count = 2'd2;
              res_d.seg0_len  = room;
              res_d.seg1_len  = total - room;
            end else begin
              res_d.seg_count = 2'd1;
              res_d.seg0_len  = total;
            end
          end
        end
      endcase
    end
    if (cfg_i.clear) begin
      fill_d = '0;
      rp_d   = '0;
      wp_d   = '0;
      bok_d  = 1'b0;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rp_q   <= '0;
      wp_q   <= '0;
      bok_q  <= 1'b0;
      vld_q  <= 1'b0;
      rsel_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      bok_q  <= bok_d;
      vld_q  <= vld_d;
      rsel_q <= rsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    out_data_o          = res_q;
    out_data_o.byte_out = rsel_q ? mem_rdata_i : 8'd0;
  end

  assign out_valid_o = vld_q;

endmodule

>>> rtl/byte_ring_buffer_dma_window.sv
// top level of the byte ring buffer with dma segment reporting
// result: valid in the cycle after its transaction is accepted
// throughput: one transaction per cycle, set by the single store read port
// and the result register; input stalls only while a result is held back
// reset: asynchronous active low, buffer empty, capacity 4096, store contents undefined
`timescale 1ns / 1ps
module byte_ring_buffer_dma_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbdw_pkg::APB_AW-1:0] paddr,
  input  logic [rbdw_pkg::APB_DW-1:0] pwdata,
  output logic [rbdw_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rbdw_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rbdw_pkg::out_t              out_data_o
);

  rbdw_pkg::cfg_t     cfg;
  rbdw_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;

  rbdw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbdw_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rbdw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule
